// File: design/assert_macros.svh
// assertion helpers included by the generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b on the same clock edge
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// a implies b on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// File: design/gplg_pkg.sv
// ----------------------------------------------------------------------------
// gplg_pkg
// constants and types of the polar gaussian generator
// ----------------------------------------------------------------------------
package gplg_pkg;
	localparam int FRACTION_BITS_DEF = 32;
	localparam int LAG_LEN = 55;
	localparam int LAG_FAR = 31;
	localparam int LAG_NEAR = 54;
	localparam int LCG_MUL = 2349;
	localparam int LCG_ADD = 14867;
	localparam int LCG_MOD = 32767;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SEED_LCG,
		ST_SEED_MUL,
		ST_SEED_DIV,
		ST_SEED_WR,
		ST_U_RD,
		ST_U_ADD,
		ST_SQ,
		ST_CHECK,
		ST_NORM,
		ST_LOG,
		ST_LN_HI,
		ST_LN_LO,
		ST_DIV,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_SQRT,
		ST_DONE
	} gplg_state_t;
endpackage

// File: design/gplg_stream_if.sv
// ----------------------------------------------------------------------------
// gplg_stream_if
// valid/ready channel carrying a payload of parameterised type
// ----------------------------------------------------------------------------
interface gplg_stream_if #(parameter type PAYLOAD_T = logic) ();
	logic valid;
	logic ready;
	PAYLOAD_T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: design/gaussian_polar_lagged_generator.sv
// ----------------------------------------------------------------------------
// gaussian_polar_lagged_generator
// polar-method normal deviates over an additive lagged fibonacci source
// ----------------------------------------------------------------------------
// in_ch carries one request word {action, seed}; out_ch one Q3.28 deviate.
// one request is handled at a time by a sequencer around a 55-entry ring
// memory (one read port, one write port, registered reads). a uniform costs
// two memory reads and a write-back; a pair is followed by its squares and a
// range check. the log is taken by repeated squaring, then come a divide and
// a square root; a rejected pair is redrawn, and a reseed or the first draw
// after reset first refills the ring (a dropped value, then each ring entry).
// a new request is taken only once the previous deviate is finished.
// the result sits in an output register; in_ch stays not ready until that
// word is taken, so a stalled receiver simply holds the block.
// reset clears the control state and marks the ring as unseeded; the ring
// itself needs no clearing since it is always filled before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module gaussian_polar_lagged_generator
	import gplg_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	gplg_stream_if.sink in_ch,
	gplg_stream_if.source out_ch
);
	localparam int FB = FRACTION_BITS;
	localparam int SEED_REP = FB / 15;
	localparam int SEED_SH = FB % 15;

	gplg_state_t state_q, state_d;

	logic [FB-1:0] ring_mem [LAG_LEN];
	logic [FB-1:0] rd_data_s1;
	logic [5:0] rd_addr, wr_addr;
	logic wr_en;
	logic [FB-1:0] wr_data;

	logic seeded_q;
	logic [5:0] wpos_q;
	logic [5:0] cnt_q;
	logic [14:0] j_q;
	logic [27:0] jm_q;
	logic [FB-1:0] frac_q;
	logic [FB-1:0] ua_q;
	logic phase_q;
	logic half_q;
	logic [31:0] a1_q, a2_q;
	logic neg_q;
	logic [63:0] r2_q, s_q;
	logic [5:0] p_q;
	logic [32:0] m_q;
	logic [31:0] f_q;
	logic [63:0] t_q;
	logic [63:0] acc_q;
	logic [63:0] rem_q;
	logic [32:0] q_q;
	logic [63:0] v_q;
	logic [63:0] y_q, bit_q;
	logic [31:0] res_q;
	logic out_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) ring_mem[wr_addr] <= wr_data;
		rd_data_s1 <= ring_mem[rd_addr];
	end

	// ring index arithmetic
	logic [5:0] w_idx, jf_idx, kn_idx;
	logic [6:0] jf_sum;
	always_comb begin
		w_idx = (wpos_q == 6'(LAG_LEN)) ? 6'd0 : wpos_q;
		jf_sum = 7'(w_idx) + 7'(LAG_FAR);
		jf_idx = (jf_sum >= 7'(LAG_LEN)) ? 6'(jf_sum - 7'(LAG_LEN)) : 6'(jf_sum);
		kn_idx = (w_idx == 6'd0) ? 6'(LAG_NEAR) : 6'(w_idx - 6'd1);
	end

	logic [FB-1:0] u_sum;
	logic [31:0] u32;
	logic [31:0] r_mag;
	logic r_neg;
	always_comb begin
		u_sum = ua_q + rd_data_s1;
		u32 = 32'({u_sum, 32'd0} >> FB);
		r_neg = ~u32[31];
		r_mag = r_neg ? 32'h8000_0000 - u32 : {1'b0, u32[30:0]};
	end

	// lcg step j = (j*2349+14867) mod 32767, j < 2^15
	logic [27:0] lcg_full;
	logic [15:0] lcg_fold;
	logic [14:0] lcg_next;
	always_comb begin
		lcg_full = 28'(jm_q + 28'(LCG_ADD));
		lcg_fold = 16'(lcg_full[27:15]) + 16'(lcg_full[14:0]);
		lcg_fold = 16'(lcg_fold[15]) + 16'(lcg_fold[14:0]);
		lcg_next = (lcg_fold >= 16'(LCG_MOD)) ? 15'(lcg_fold - 16'(LCG_MOD)) :
			lcg_fold[14:0];
	end

	// j*2^FB/32767: since 2^15 = 1 mod 32767 the quotient is j repeated every
	// 15 bits, plus floor(j*2^e/32767) for the leftover shift e
	logic [29:0] sc_y;
	logic [15:0] sc_sum;
	logic [15:0] sc_low;
	logic [FB-1:0] frac_next;
	always_comb begin
		sc_y = 30'(j_q) << SEED_SH;
		sc_sum = 16'(sc_y[29:15]) + 16'(sc_y[14:0]);
		sc_low = 16'(sc_y[29:15]) + ((sc_sum >= 16'(LCG_MOD)) ? 16'd1 : 16'd0);
		frac_next = (FB'({SEED_REP{j_q}}) << SEED_SH) + FB'(sc_low);
	end

	logic [63:0] sq_full;
	assign sq_full = {32'd0, m_q[31:0]} * {32'd0, m_q[31:0]};

	logic [63:0] div_sh;
	assign div_sh = {rem_q[62:0], 1'b0};

	logic [31:0] mult_a;
	logic [31:0] mult_b;
	logic [63:0] mult_p;
	always_comb begin
		mult_a = 32'd0;
		mult_b = 32'd0;
		case (state_q)
			ST_SQ: begin
				mult_a = cnt_q[0] ? a2_q : a1_q;
				mult_b = cnt_q[0] ? a2_q : a1_q;
			end
			ST_LN_HI: begin mult_a = t_q[63:32]; mult_b = LN2_Q32; end
			ST_LN_LO: begin mult_a = t_q[31:0]; mult_b = LN2_Q32; end
			ST_MUL_HI: begin mult_a = acc_q[63:32]; mult_b = q_q[31:0]; end
			ST_MUL_LO: begin mult_a = acc_q[31:0]; mult_b = q_q[31:0]; end
			ST_SEED_MUL: begin mult_a = 32'(j_q); mult_b = 32'(LCG_MUL); end
			default: ;
		endcase
		mult_p = {32'd0, mult_a} * {32'd0, mult_b};
	end

	// a quotient of exactly 2^32 leaves the product equal to g
	logic [63:0] v_sum;
	assign v_sum = q_q[32] ? v_q : v_q + 64'(mult_p[63:32]);

	logic [63:0] sqrt_t;
	assign sqrt_t = y_q + bit_q;

	logic [5:0] lz_p;
	always_comb begin
		lz_p = 6'd0;
		for (int i = 0; i < 64; i++) if (s_q[i]) lz_p = 6'(i);
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = res_q;

	logic in_fire;
	assign in_fire = in_ch.valid && in_ch.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire)
				state_d = (in_ch.payload[15] || !seeded_q) ? ST_SEED_MUL : ST_U_RD;
			ST_SEED_MUL: state_d = ST_SEED_LCG;
			ST_SEED_LCG: state_d = (cnt_q == 6'd0) ? ST_SEED_MUL : ST_SEED_DIV;
			ST_SEED_DIV: state_d = ST_SEED_WR;
			ST_SEED_WR: state_d = (cnt_q == 6'(LAG_LEN + 1)) ? ST_U_RD : ST_SEED_MUL;
			ST_U_RD: state_d = half_q ? ST_U_ADD : ST_U_RD;
			ST_U_ADD: state_d = phase_q ? ST_SQ : ST_U_RD;
			ST_SQ: if (cnt_q[0]) state_d = ST_CHECK;
			ST_CHECK: state_d = s_q[63:62] != 2'd0 ? ST_U_RD : ST_NORM;
			ST_NORM: state_d = ST_LOG;
			ST_LOG: if (cnt_q == 6'd31) state_d = ST_LN_HI;
			ST_LN_HI: state_d = ST_LN_LO;
			ST_LN_LO: state_d = ST_DIV;
			ST_DIV: if (cnt_q == 6'd32) state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_SQRT;
			ST_SQRT: if (bit_q[63:2] == 62'd0) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_addr = half_q ? kn_idx : jf_idx;
		wr_en = 1'b0;
		wr_addr = w_idx;
		wr_data = u_sum;
		case (state_q)
			ST_SEED_WR: begin
				wr_en = 1'b1;
				wr_addr = 6'(cnt_q - 6'd2);
				wr_data = frac_q;
			end
			ST_U_ADD: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seeded_q <= 1'b0;
			wpos_q <= 6'(LAG_LEN);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			if (state_q == ST_SEED_WR && cnt_q == 6'(LAG_LEN + 1)) begin
				seeded_q <= 1'b1;
				wpos_q <= 6'(LAG_LEN);
			end
			if (state_q == ST_U_ADD) wpos_q <= 6'(w_idx + 6'd1);
			if (state_q == ST_DONE) out_valid_q <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				j_q <= in_ch.payload[15] ? in_ch.payload[14:0] : 15'd0;
				cnt_q <= 6'd0;
				half_q <= 1'b0;
				phase_q <= 1'b0;
			end
			ST_SEED_MUL: jm_q <= mult_p[27:0];
			ST_SEED_LCG: begin
				j_q <= lcg_next;
				cnt_q <= 6'(cnt_q + 6'd1);
			end
			ST_SEED_DIV: frac_q <= frac_next;
			ST_U_RD: begin
				half_q <= ~half_q;
				if (half_q) ua_q <= rd_data_s1;
			end
			ST_U_ADD: begin
				phase_q <= ~phase_q;
				if (!phase_q) begin a1_q <= r_mag; neg_q <= r_neg; end
				else a2_q <= r_mag;
				cnt_q <= 6'd0;
			end
			ST_SQ: begin
				cnt_q <= 6'(cnt_q + 6'd1);
				if (!cnt_q[0]) r2_q <= mult_p;
				else s_q <= r2_q + mult_p;
			end
			ST_CHECK: begin
				if (s_q == 64'd0) s_q <= 64'd1;
				cnt_q <= 6'd0;
			end
			ST_NORM: begin
				p_q <= lz_p;
				m_q <= (lz_p >= 6'd31) ? 33'(s_q >> (lz_p - 6'd31)) :
					33'(s_q << (6'd31 - lz_p));
				f_q <= 32'd0;
			end
			ST_LOG: begin
				cnt_q <= 6'(cnt_q + 6'd1);
				if (sq_full[63]) begin
					m_q <= 33'(sq_full[63:32]);
					f_q <= {f_q[30:0], 1'b1};
				end else begin
					m_q <= 33'(sq_full[62:31]);
					f_q <= {f_q[30:0], 1'b0};
				end
				if (cnt_q == 6'd31) begin
					t_q <= {32'(7'd62 - 7'(p_q)), 32'd0} -
						64'({f_q[30:0], sq_full[63]});
				end
			end
			ST_LN_HI: acc_q <= mult_p;
			ST_LN_LO: begin
				acc_q <= {acc_q[62:0], 1'b0} + {31'd0, mult_p[63:31]} & ~64'd1
					| 64'(0);
				cnt_q <= 6'd0;
				if (r2_q >= s_q) begin rem_q <= r2_q - s_q; q_q <= 33'd1; end
				else begin rem_q <= r2_q; q_q <= 33'd0; end
			end
			ST_DIV: begin
				cnt_q <= 6'(cnt_q + 6'd1);
				if (cnt_q != 6'd32) begin
					if (div_sh >= s_q) begin
						rem_q <= div_sh - s_q;
						q_q <= {q_q[31:0], 1'b1};
					end else begin
						rem_q <= div_sh;
						q_q <= {q_q[31:0], 1'b0};
					end
				end
			end
			ST_MUL_HI: v_q <= q_q[32] ? acc_q : mult_p;
			ST_MUL_LO: begin
				v_q <= v_sum;
				rem_q <= v_sum << 24;
				y_q <= 64'd0;
				bit_q <= 64'd1 << 62;
			end
			ST_SQRT: begin
				if (rem_q >= sqrt_t) begin
					rem_q <= rem_q - sqrt_t;
					y_q <= (y_q >> 1) + bit_q;
				end else begin
					y_q <= y_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DONE: begin
				if (neg_q) begin
					res_q <= ((y_q + 64'(rem_q > y_q)) > 64'h8000_0000) ?
						32'h8000_0000 : 32'(64'd0 - (y_q + 64'(rem_q > y_q)));
				end else begin
					res_q <= ((y_q + 64'(rem_q > y_q)) > 64'h7FFF_FFFF) ?
						32'h7FFF_FFFF : 32'(y_q + 64'(rem_q > y_q));
				end
			end
			default: ;
		endcase
	end

	`ASSERT_IMPLY(a_ready_idle, clk, arst_n, in_ch.ready, state_q == ST_IDLE)
	`ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == ST_DONE, out_valid_q)
	`ASSERT_IMPLY(a_wpos_range, clk, arst_n, 1'b1, wpos_q <= 6'(LAG_LEN))
endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks gaussian_polar_lagged_generator against a bit-exact deviate predictor
// ----------------------------------------------------------------------------
// request words {action, seed} are queued by an initial block and fed by a
// clocked driver with random gaps. each accepted request is run through a local
// copy of the lagged ring, polar rejection, fixed-point log, divide and root.
// the monitor takes deviates with random stalls, including one long hold,
// and compares each against the oldest predicted deviate.
// ----------------------------------------------------------------------------
module tb_top;
	import gplg_pkg::*;

	localparam int RAND_ITEMS = 1880;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int LONG_HOLD_AT = 120;
	localparam int LONG_HOLD_LEN = 600;
	localparam int DRAIN_AT = 900;

	typedef enum logic {ACT_DRAW = 1'b0, ACT_RESEED = 1'b1} action_t;

	logic clk;
	logic arst_n;

	gplg_stream_if #(.PAYLOAD_T(logic [15:0])) in_ch ();
	gplg_stream_if #(.PAYLOAD_T(logic [31:0])) out_ch ();

	gaussian_polar_lagged_generator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [15:0] pending_requests[$];
	logic [31:0] expected_deviates[$];
	int errors = 0;
	int words_sent = 0;
	int words_taken = 0;
	int send_gap = 0;
	int take_stall = 0;
	longint cycles = 0;

	// predictor copy of the ring
	logic [31:0] ring[LAG_LEN];
	int ring_pos = LAG_LEN;
	bit ring_seeded = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic void fill_ring(input logic [14:0] seed);
		logic [63:0] j;
		j = seed;
		for (int i = 0; i <= LAG_LEN; i++) begin
			j = (j * LCG_MUL + LCG_ADD) % LCG_MOD;
			if (i >= 1)
				ring[i - 1] = 32'((j << 32) / LCG_MOD);
		end
		ring_pos = LAG_LEN;
		ring_seeded = 1;
	endfunction

	function automatic logic [31:0] next_fraction();
		int n;
		int w;
		logic [31:0] u;
		n = ring_pos % LAG_LEN + 1;
		w = n - 1;
		u = ring[(w + LAG_FAR) % LAG_LEN] + ring[(w + LAG_NEAR) % LAG_LEN];
		ring[w] = u;
		ring_pos = n;
		return u;
	endfunction

	// -ln of s * 2^-62 in Q.32
	function automatic logic [63:0] minus_ln(input logic [63:0] s);
		int p;
		logic [63:0] m;
		logic [63:0] f;
		logic [63:0] t;
		p = 0;
		f = 0;
		while (p < 63 && (s >> (p + 1)) != 0)
			p++;
		m = (p >= 31) ? s >> (p - 31) : s << (31 - p);
		for (int i = 0; i < 32; i++) begin
			m = (m * m) >> 31;
			f = f << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				f = f | 64'd1;
			end
		end
		t = (64'(62 - p) << 32) - f;
		return (t >> 32) * LN2_Q32 + (((t & 64'hFFFF_FFFF) * LN2_Q32) >> 32);
	endfunction

	function automatic logic [63:0] root_nearest(input logic [63:0] n);
		logic [63:0] y;
		logic [63:0] b;
		logic [63:0] rem;
		y = 0;
		b = 64'd1 << 62;
		rem = n;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= y + b) begin
				rem = rem - (y + b);
				y = (y >> 1) + b;
			end else begin
				y = y >> 1;
			end
			b = b >> 2;
		end
		if (rem > y)
			y++;
		return y;
	endfunction

	function automatic logic [31:0] predict_deviate(input logic [15:0] req);
		logic [63:0] u1;
		logic [63:0] u2;
		logic [63:0] a1;
		logic [63:0] a2;
		logic [63:0] r2;
		logic [63:0] s;
		logic [63:0] g;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] v;
		logic [63:0] y;
		bit neg;
		if (action_t'(req[15]) == ACT_RESEED)
			fill_ring(req[14:0]);
		else if (!ring_seeded)
			fill_ring(15'd0);
		do begin
			u1 = next_fraction();
			u2 = next_fraction();
			neg = u1 < 64'h8000_0000;
			a1 = neg ? 64'h8000_0000 - u1 : u1 - 64'h8000_0000;
			a2 = (u2 < 64'h8000_0000) ? 64'h8000_0000 - u2 : u2 - 64'h8000_0000;
			r2 = a1 * a1;
			s = r2 + a2 * a2;
		end while (s >= (64'd1 << 62));
		if (s == 0)
			s = 1;
		g = 2 * minus_ln(s);
		q = 0;
		rem = r2;
		if (rem >= s) begin
			rem = rem - s;
			q = 1;
		end
		for (int i = 0; i < 32; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= s) begin
				rem = rem - s;
				q = q | 64'd1;
			end
		end
		v = (g >> 32) * q + (((g & 64'hFFFF_FFFF) * q) >> 32);
		y = root_nearest(v << 24);
		if (neg) begin
			if (y > 64'h8000_0000)
				y = 64'h8000_0000;
			return 32'(64'd0 - y);
		end
		if (y > 64'h7FFF_FFFF)
			y = 64'h7FFF_FFFF;
		return y[31:0];
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic accepted;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= '0;
		end else begin
			accepted = in_ch.valid && in_ch.ready;
			if (accepted) begin
				expected_deviates.push_back(predict_deviate(pending_requests.pop_front()));
				words_sent++;
				// a stretch with no gaps
				send_gap = (words_sent >= 400 && words_sent < 600) ? 0 : $urandom_range(0, 6);
			end
			if (!in_ch.valid || accepted) begin
				if (send_gap != 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_requests.size() != 0 &&
						!(words_sent == DRAIN_AT && expected_deviates.size() != 0)) begin
					in_ch.valid <= 1'b1;
					in_ch.payload <= pending_requests[0];
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_deviates.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", out_ch.payload));
				end else begin
					want = expected_deviates.pop_front();
					if (out_ch.payload !== want)
						report_mismatch($sformatf("word %0d normal_value %h, want %h",
							words_taken, out_ch.payload, want));
				end
				words_taken++;
				if (words_taken == LONG_HOLD_AT)
					take_stall = LONG_HOLD_LEN;
				else if (words_taken >= 1200 && words_taken < 1400)
					take_stall = 0;
				else
					take_stall = $urandom_range(0, 6);
				out_ch.ready <= (take_stall == 0);
			end else if (take_stall != 0) begin
				take_stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] req;
		arst_n = 1'b0;
		// draw before any reseed, then seed extremes
		pending_requests.push_back({ACT_DRAW, 15'd12345});
		pending_requests.push_back({ACT_DRAW, 15'h7FFF});
		pending_requests.push_back({ACT_RESEED, 15'd0});
		pending_requests.push_back({ACT_DRAW, 15'd0});
		pending_requests.push_back({ACT_RESEED, 15'd32766});
		pending_requests.push_back({ACT_DRAW, 15'h5555});
		pending_requests.push_back({ACT_RESEED, 15'd32767});
		pending_requests.push_back({ACT_DRAW, 15'h2AAA});
		pending_requests.push_back({ACT_RESEED, 15'd1});
		for (int i = 0; i < 10; i++)
			pending_requests.push_back({ACT_DRAW, 15'($urandom)});
		pending_requests.push_back({ACT_RESEED, 15'h4000});
		for (int i = 0; i < RAND_ITEMS; i++) begin
			req[14:0] = 15'($urandom);
			req[15] = ($urandom_range(0, 9) == 0) ? ACT_RESEED : ACT_DRAW;
			pending_requests.push_back(req);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_requests.size() == 0 && expected_deviates.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
